// ===== hdl/rws_pkg.sv =====
// Shared types and constants for the roulette wheel selector.
// Used by rws_ctrl, rws_dp and roulette_wheel_selector; depends on nothing.
package rws_pkg;

   localparam int POP_MAX = 256;
   localparam int IDX_W   = $clog2(POP_MAX);
   localparam int CNT_W   = $clog2(POP_MAX + 1);
   localparam int FIT_W   = 16;
   localparam int DRAW_W  = 16;
   localparam int TOT_W   = FIT_W + IDX_W;
   localparam int TGT_W   = DRAW_W + TOT_W;
   localparam int SIZE_W  = 9;
   localparam int EIDX_W  = 8;
   localparam int OUT_W   = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SELECT = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_POP_SIZE = CSR_AW'(0);
   localparam logic [SIZE_W-1:0] POP_SIZE_RST = SIZE_W'(256);

   typedef struct packed {
      logic write_mem;
      logic capture;
      logic issue;
      logic sum;
      logic walk;
      logic mul;
      logic take_last;
      logic emit;
   } rws_cmd_type;

   typedef struct packed {
      logic issue_done;
      logic rd_valid;
      logic hit;
      logic out_free;
   } rws_stat_type;

endpackage

// ===== hdl/rws_ctrl.sv =====
// Sequencer for the roulette wheel selector: accepts transactions and
// steps the datapath through the sum pass, multiply and prefix walk. Uses rws_pkg.
module rws_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_ready,
   input  rws_pkg::rws_stat_type stat,
   output rws_pkg::rws_cmd_type  cmd
);
   import rws_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SUM  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_WALK = 6'b001000,
      ST_DONE = 6'b010000,
      ST_SPARE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_SELECT) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SUM;
               end else begin
                  cmd.write_mem = 1'b1;
               end
            end
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (stat.issue_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            priority if (stat.hit) begin
               state_in = ST_DONE;
            end else if (stat.issue_done && !stat.rd_valid) begin
               cmd.take_last = 1'b1;
               state_in      = ST_DONE;
            end else if (!stat.issue_done) begin
               cmd.issue = 1'b1;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/rws_dp.sv =====
// Datapath for the roulette wheel selector: fitness memory, read counter,
// total and prefix accumulators, target multiplier and result register. Uses rws_pkg.
module rws_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rws_pkg::rws_cmd_type          cmd,
   input  logic [rws_pkg::EIDX_W-1:0]    req_entry_index,
   input  logic [rws_pkg::FIT_W-1:0]     req_fitness_value,
   input  logic [rws_pkg::DRAW_W-1:0]    req_random_draw,
   input  logic [rws_pkg::SIZE_W-1:0]    pop_size,
   input  logic                          rsp_ready,
   output rws_pkg::rws_stat_type         stat,
   output logic                          rsp_valid,
   output logic [rws_pkg::OUT_W-1:0]     rsp_chosen_index
);
   import rws_pkg::*;

   logic [FIT_W-1:0]  fitness_mem [POP_MAX];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  limit;
   logic              rd_valid_ff;
   logic [FIT_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [DRAW_W-1:0] draw_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [TOT_W-1:0]  prefix_ff;
   logic [TOT_W-1:0]  prefix_sum;
   logic [TGT_W-1:0]  target_ff;
   logic [TGT_W-1:0]  product;
   logic              hit;
   logic [OUT_W-1:0]  result_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      if (pop_size == '0) begin
         count_in = CNT_W'(1);
      end else if (32'(pop_size) > POP_MAX) begin
         count_in = CNT_W'(POP_MAX);
      end else begin
         count_in = CNT_W'(pop_size);
      end
   end

   assign limit      = cmd.walk ? (count_ff - CNT_W'(1)) : count_ff;
   assign prefix_sum = prefix_ff + TOT_W'(rd_data_ff);
   assign product    = TGT_W'(draw_ff) * TGT_W'(total_ff);
   assign hit        = cmd.walk && rd_valid_ff && (target_ff < {prefix_sum, {DRAW_W{1'b0}}});

   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture || cmd.mul) begin
         addr_in = '0;
      end else if (cmd.issue) begin
         addr_in = addr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         rd_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_mem && (32'(req_entry_index) < POP_MAX)) begin
         fitness_mem[IDX_W'(req_entry_index)] <= req_fitness_value;
      end
      if (cmd.issue) begin
         rd_data_ff <= fitness_mem[addr_ff[IDX_W-1:0]];
         rd_idx_ff  <= addr_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         draw_ff   <= req_random_draw;
         count_ff  <= count_in;
         total_ff  <= '0;
         prefix_ff <= '0;
      end else begin
         if (cmd.sum && rd_valid_ff) begin
            total_ff <= total_ff + TOT_W'(rd_data_ff);
         end
         if (cmd.walk && rd_valid_ff) begin
            prefix_ff <= prefix_sum;
         end
      end
      if (cmd.mul) begin
         target_ff <= product;
      end
      if (hit) begin
         result_ff <= OUT_W'(rd_idx_ff);
      end else if (cmd.take_last) begin
         result_ff <= OUT_W'(count_ff - CNT_W'(1));
      end
      if (cmd.emit) begin
         rsp_chosen_index <= result_ff;
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign stat.issue_done = (addr_ff == limit);
   assign stat.rd_valid   = rd_valid_ff;
   assign stat.hit        = hit;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ===== hdl/roulette_wheel_selector.sv =====
// Roulette wheel selector top level: register port, sequencer and datapath.
// Instantiates rws_ctrl and rws_dp; uses rws_pkg.
//
// A write transaction stores one fitness value. A select transaction
// works over the active population size: the single read port of the
// fitness memory walks the table once to form the total and once more for
// the running prefix, one entry per cycle, and the walk stops early at the
// chosen entry. New transactions are taken while a result waits in the
// output register. The fitness memory is not cleared by reset; every entry
// in the active range must be written before a select.
module roulette_wheel_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [rws_pkg::EIDX_W-1:0]    req_entry_index,
   input  logic [rws_pkg::FIT_W-1:0]     req_fitness_value,
   input  logic [rws_pkg::DRAW_W-1:0]    req_random_draw,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rws_pkg::OUT_W-1:0]     rsp_chosen_index,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rws_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [rws_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [rws_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import rws_pkg::*;

   rws_cmd_type       cmd;
   rws_stat_type      stat;
   logic [SIZE_W-1:0] pop_size_ff;
   logic              csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = ({csr_paddr[CSR_AW-1:2], 2'b00} == CSR_POP_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff <= POP_SIZE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         pop_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DW'(pop_size_ff) : '0;

   rws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rws_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_entry_index   (req_entry_index),
      .req_fitness_value (req_fitness_value),
      .req_random_draw   (req_random_draw),
      .pop_size          (pop_size_ff),
      .rsp_ready         (rsp_ready),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_chosen_index  (rsp_chosen_index)
   );

`ifndef ASSERT_OFF
   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_SELECT) |=> !req_ready)
      else $error("ready stayed high after a select transaction");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result not presented after emit");

   a_read_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !stat.issue_done)
      else $error("fitness read beyond the active range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result emitted over a pending result");
`endif

endmodule
